>>> hw/rtl/skt_pkg.sv
`default_nettype none

package skt_pkg;

    // Table size and derived widths.
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths of the command and result ports.
    localparam int CMD_W    = 3;
    localparam int KEY_W    = 14;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 10;
    localparam int COUNT_W  = 11;

    // One stored entry is the key with its flag in the low bit.
    localparam int ENTRY_W  = KEY_W + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 3'd0,
        CMD_UPDATE  = 3'd1,
        CMD_DELETE  = 3'd2,
        CMD_LOOKUP  = 3'd3,
        CMD_SAVE    = 3'd4,
        CMD_RESTORE = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_FULL        = 3'd1,
        ST_NOT_FOUND   = 3'd2,
        ST_DUPLICATE   = 3'd3,
        ST_NO_SNAPSHOT = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SREAD,
        S_SCMP,
        S_PCHK,
        S_MOVE,
        S_DRAIN,
        S_PUT,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/sorted_key_table_top.sv
// Sorted key table: one command item at a time, result shown for one cycle on done.
// Lookup, update, insert and delete first run a binary search over the stored entries;
// insert, delete, save and restore also shift or copy entries one by one.
// A new item is taken in the idle cycle after done.
// The receiver cannot stall: each result is valid only in its done cycle.
// Reset (rst_n low, asynchronous) empties the table and drops the snapshot; no memory sweep.
`default_nettype none

module sorted_key_table_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [skt_pkg::CMD_W-1:0]    command,
    input  logic [skt_pkg::KEY_W-1:0]    key,
    input  logic                         flag_in,
    output logic                         done,
    output logic [skt_pkg::STATUS_W-1:0] status,
    output logic [skt_pkg::POS_W-1:0]    position,
    output logic                         flag_out,
    output logic [skt_pkg::COUNT_W-1:0]  count
);

    import skt_pkg::*;

    // The design is a small sequencer around two RAMs. The table RAM holds the
    // sorted entries; the snapshot RAM holds the saved copy. Both have one write
    // port and one registered read port, and the single read port of the table
    // is shared between the binary search and the shift engine.

    state_t              state_reg, state_next;

    // Latched command item.
    cmd_t                op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic                fin_reg, fin_next;

    // Architectural counters.
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    saved_count_reg, saved_count_next;
    logic                snap_valid_reg, snap_valid_next;

    // Binary search bounds; lo_reg ends as the lower-bound position.
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [CNT_W-1:0]    mid;

    // Shift and copy engine: idx_reg is the next read index, end_reg the last
    // one, and widx_reg the write address of the entry read in the cycle before.
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    end_reg, end_next;
    logic [ADDR_W-1:0]   widx_reg, widx_next;
    logic                pend_reg, pend_next;

    // Result registers.
    status_t             status_reg, status_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                fout_reg, fout_next;

    // RAM ports.
    logic                tbl_we, snap_we;
    logic [ADDR_W-1:0]   tbl_waddr, tbl_raddr;
    logic [ENTRY_W-1:0]  tbl_wdata, tbl_rdata;
    logic [ENTRY_W-1:0]  snap_wdata, snap_rdata;

    logic [KEY_W-1:0]    rd_key;
    logic                rd_flag;
    logic                hit;
    logic                last;
    logic [ENTRY_W-1:0]  src_data;

    skt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // The snapshot is only ever copied to and from, one entry per cycle, so its
    // read and write addresses both come from the shift engine.
    skt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_snap (
        .clk   (clk),
        .we    (snap_we),
        .waddr (widx_reg),
        .wdata (snap_wdata),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (snap_rdata)
    );

    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign rd_key   = tbl_rdata[ENTRY_W-1:1];
    assign rd_flag  = tbl_rdata[0];
    // The probe at the lower bound only counts as a hit inside the valid range.
    assign hit      = (lo_reg < count_reg) && (rd_key == key_reg);
    assign last     = (idx_reg == end_reg);
    // A restore reads the snapshot; every other move reads the table.
    assign src_data = (op_reg == CMD_RESTORE) ? snap_rdata : tbl_rdata;

    assign busy     = (state_reg != S_IDLE);
    assign done     = (state_reg == S_DONE);
    assign status   = status_reg;
    assign position = pos_reg;
    assign flag_out = fout_reg;
    assign count    = COUNT_W'(count_reg);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    priority case (cmd_t'(command))
                        CMD_INSERT:
                        begin
                            state_next = (count_reg >= CNT_W'(CAPACITY)) ? S_DONE : S_SREAD;
                        end
                        CMD_UPDATE, CMD_DELETE, CMD_LOOKUP:
                        begin
                            state_next = S_SREAD;
                        end
                        CMD_SAVE:
                        begin
                            state_next = (count_reg == '0) ? S_DONE : S_MOVE;
                        end
                        CMD_RESTORE:
                        begin
                            if (!snap_valid_reg || (saved_count_reg == '0))
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_MOVE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SREAD:
            begin
                state_next = (lo_reg < hi_reg) ? S_SCMP : S_PCHK;
            end
            S_SCMP:
            begin
                state_next = S_SREAD;
            end
            S_PCHK:
            begin
                priority case (op_reg)
                    CMD_INSERT:
                    begin
                        if (hit)
                        begin
                            state_next = S_DONE;
                        end
                        else if (lo_reg == count_reg)
                        begin
                            state_next = S_PUT;
                        end
                        else
                        begin
                            state_next = S_MOVE;
                        end
                    end
                    CMD_UPDATE:
                    begin
                        state_next = hit ? S_PUT : S_DONE;
                    end
                    CMD_DELETE:
                    begin
                        if (hit && ((lo_reg + CNT_W'(1)) != count_reg))
                        begin
                            state_next = S_MOVE;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_MOVE:
            begin
                state_next = last ? S_DRAIN : S_MOVE;
            end
            S_DRAIN:
            begin
                state_next = (op_reg == CMD_INSERT) ? S_PUT : S_DONE;
            end
            S_PUT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and RAM control.
    always_comb
    begin
        op_next          = op_reg;
        key_next         = key_reg;
        fin_next         = fin_reg;
        count_next       = count_reg;
        saved_count_next = saved_count_reg;
        snap_valid_next  = snap_valid_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        idx_next         = idx_reg;
        end_next         = end_reg;
        widx_next        = widx_reg;
        pend_next        = pend_reg;
        status_next      = status_reg;
        pos_next         = pos_reg;
        fout_next        = fout_reg;

        tbl_we           = 1'b0;
        tbl_waddr        = widx_reg;
        tbl_wdata        = src_data;
        tbl_raddr        = idx_reg[ADDR_W-1:0];
        snap_we          = 1'b0;
        snap_wdata       = tbl_rdata;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = cmd_t'(command);
                    key_next    = key;
                    fin_next    = flag_in;
                    status_next = ST_OK;
                    pos_next    = '0;
                    fout_next   = 1'b0;
                    lo_next     = '0;
                    hi_next     = count_reg;
                    idx_next    = '0;
                    pend_next   = 1'b0;
                    priority case (cmd_t'(command))
                        CMD_INSERT:
                        begin
                            if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                        end
                        CMD_SAVE:
                        begin
                            end_next = count_reg - CNT_W'(1);
                            if (count_reg == '0)
                            begin
                                saved_count_next = '0;
                                snap_valid_next  = 1'b1;
                            end
                        end
                        CMD_RESTORE:
                        begin
                            end_next = saved_count_reg - CNT_W'(1);
                            if (!snap_valid_reg)
                            begin
                                status_next = ST_NO_SNAPSHOT;
                            end
                            else if (saved_count_reg == '0)
                            begin
                                count_next = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SREAD:
            begin
                // Probe the midpoint, or the final lower bound once the range is empty.
                tbl_raddr = (lo_reg < hi_reg) ? mid[ADDR_W-1:0] : lo_reg[ADDR_W-1:0];
            end
            S_SCMP:
            begin
                if (rd_key < key_reg)
                begin
                    lo_next = mid + CNT_W'(1);
                end
                else
                begin
                    hi_next = mid;
                end
            end
            S_PCHK:
            begin
                priority case (op_reg)
                    CMD_INSERT:
                    begin
                        pos_next = POS_W'(lo_reg);
                        if (hit)
                        begin
                            status_next = ST_DUPLICATE;
                        end
                        else
                        begin
                            // Shift entries from the top down to the insert position.
                            idx_next = count_reg - CNT_W'(1);
                            end_next = lo_reg;
                        end
                    end
                    CMD_UPDATE, CMD_LOOKUP, CMD_DELETE:
                    begin
                        if (!hit)
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                        else
                        begin
                            pos_next = POS_W'(lo_reg);
                            if (op_reg == CMD_LOOKUP)
                            begin
                                fout_next = rd_flag;
                            end
                            else if (op_reg == CMD_DELETE)
                            begin
                                // Shift the entries above the hole down by one.
                                idx_next = lo_reg + CNT_W'(1);
                                end_next = count_reg - CNT_W'(1);
                                if ((lo_reg + CNT_W'(1)) == count_reg)
                                begin
                                    count_next = count_reg - CNT_W'(1);
                                end
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_MOVE:
            begin
                // Read one entry per cycle and write the entry that the previous read returned.
                if (op_reg == CMD_SAVE)
                begin
                    snap_we = pend_reg;
                end
                else
                begin
                    tbl_we = pend_reg;
                end
                pend_next = 1'b1;
                priority case (op_reg)
                    CMD_INSERT:
                    begin
                        widx_next = ADDR_W'(idx_reg + CNT_W'(1));
                    end
                    CMD_DELETE:
                    begin
                        widx_next = ADDR_W'(idx_reg - CNT_W'(1));
                    end
                    default:
                    begin
                        widx_next = idx_reg[ADDR_W-1:0];
                    end
                endcase
                if (!last)
                begin
                    idx_next = (op_reg == CMD_INSERT) ? (idx_reg - CNT_W'(1))
                                                      : (idx_reg + CNT_W'(1));
                end
            end
            S_DRAIN:
            begin
                pend_next = 1'b0;
                priority case (op_reg)
                    CMD_SAVE:
                    begin
                        snap_we          = 1'b1;
                        saved_count_next = count_reg;
                        snap_valid_next  = 1'b1;
                    end
                    CMD_RESTORE:
                    begin
                        tbl_we     = 1'b1;
                        count_next = saved_count_reg;
                    end
                    CMD_DELETE:
                    begin
                        tbl_we     = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                    default:
                    begin
                        tbl_we = 1'b1;
                    end
                endcase
            end
            S_PUT:
            begin
                // Insert places the new entry; update rewrites the flag in place.
                tbl_we    = 1'b1;
                tbl_waddr = lo_reg[ADDR_W-1:0];
                tbl_wdata = {key_reg, fin_reg};
                if (op_reg == CMD_INSERT)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            saved_count_reg <= '0;
            snap_valid_reg  <= 1'b0;
            pend_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            saved_count_reg <= saved_count_next;
            snap_valid_reg  <= snap_valid_next;
            pend_reg        <= pend_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        fin_reg    <= fin_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        idx_reg    <= idx_next;
        end_reg    <= end_next;
        widx_reg   <= widx_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
        fout_reg   <= fout_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/skt_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module skt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/skt_checker.sv
`default_nettype none

module skt_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic                         done,
    input  logic [skt_pkg::STATUS_W-1:0] status,
    input  logic [skt_pkg::POS_W-1:0]    position,
    input  logic                         flag_out,
    input  logic [skt_pkg::COUNT_W-1:0]  count
);

    import skt_pkg::*;

    // An accepted item makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // A result is only shown while the item is still in progress.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    // Each item yields one result, shown for a single cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // A set flag only comes back from a successful lookup.
    a_flag_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && flag_out) |-> (status == ST_OK))
        else $error("flag_out set on a failing result");

    // A full-table result reports a full count and position zero.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FULL)) |-> ((count == COUNT_W'(CAPACITY)) && (position == '0)))
        else $error("table full reported with wrong count or position");

endmodule

bind sorted_key_table_top skt_checker u_skt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .status   (status),
    .position (position),
    .flag_out (flag_out),
    .count    (count)
);

`default_nettype wire

>>> tb/sorted_key_table_top_tb.sv
`default_nettype none

// Testbench for the sorted key table.
//
// An initial block queues every command item up front: a short directed set
// and three random phases with different sender idling. A clocked driver
// presents the queued items on the start/busy handshake. It also runs each
// accepted item through a behavioral copy of the table, which pushes the
// expected result. A clocked monitor compares each done strobe with the
// oldest expected result. The receiver cannot hold results off, so only the
// sender side idles.
module sorted_key_table_top_tb;
    import skt_pkg::*;

    // The two command codes that the block treats as no operation.
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    // The longest command shifts or copies the whole table; STALL_LIMIT lies far
    // above that, so reaching it with nothing moving means the block hung.
    localparam int STALL_LIMIT = 8 * (CAPACITY + 64);
    localparam int DRAIN_CYCLES = CAPACITY + 200;
    localparam int RANDOM_PHASE_ITEMS = 185;
    localparam int POOL_SIZE = 40;

    // One command item, with the sender's idling for it. The hold_off bit
    // makes the driver wait until every earlier result has come back.
    typedef struct {
        logic [CMD_W-1:0] op;
        logic [KEY_W-1:0] k;
        logic             f;
        int               idle_pct;
        bit               hold_off;
    } table_cmd_t;

    typedef struct {
        status_t            status;
        logic [POS_W-1:0]   pos;
        logic               flag;
        logic [COUNT_W-1:0] count;
    } table_result_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [CMD_W-1:0]   command;
    logic [KEY_W-1:0]   key;
    logic               flag_in;
    logic               done;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]   position;
    logic               flag_out;
    logic [COUNT_W-1:0] count;

    table_cmd_t    pending_cmds[$];
    table_result_t expected_results[$];

    // Accepted items and received results, each counted by its own process.
    int unsigned issued_n;
    int unsigned received_n;
    int          error_n;
    int          stall_n;

    // Behavioral copy of the table and of its snapshot.
    logic [KEY_W-1:0] tab_keys[CAPACITY];
    logic             tab_flags[CAPACITY];
    int unsigned      tab_n;
    logic [KEY_W-1:0] snap_keys[CAPACITY];
    logic             snap_flags[CAPACITY];
    int unsigned      snap_n;
    bit               snap_ok;

    sorted_key_table_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .command  (command),
        .key      (key),
        .flag_in  (flag_in),
        .done     (done),
        .status   (status),
        .position (position),
        .flag_out (flag_out),
        .count    (count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        error_n++;
    endtask

    // Binary search over the valid entries only: the first index whose key
    // is not below k, or tab_n when every key is below it.
    function automatic int unsigned first_not_below(input logic [KEY_W-1:0] k);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = tab_n;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (tab_keys[mid] < k)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    // Applies one accepted command to the table copy and queues the result
    // that the block must return for it.
    task automatic predict_table_result(input logic [CMD_W-1:0] op,
                                        input logic [KEY_W-1:0] k,
                                        input logic f);
        table_result_t r;
        int unsigned   p;
        int unsigned   i;
        bit            hit;
        r.status = ST_OK;
        r.pos = '0;
        r.flag = 1'b0;
        p = first_not_below(k);
        hit = (p < tab_n) && (tab_keys[p] == k);
        case (op)
            CMD_INSERT:
            begin
                // Fullness wins over a duplicate key.
                if (tab_n >= CAPACITY)
                    r.status = ST_FULL;
                else if (hit)
                begin
                    r.status = ST_DUPLICATE;
                    r.pos = p[POS_W-1:0];
                end
                else
                begin
                    for (i = tab_n; i > p; i--)
                    begin
                        tab_keys[i] = tab_keys[i-1];
                        tab_flags[i] = tab_flags[i-1];
                    end
                    tab_keys[p] = k;
                    tab_flags[p] = f;
                    tab_n++;
                    r.pos = p[POS_W-1:0];
                end
            end
            CMD_UPDATE, CMD_DELETE, CMD_LOOKUP:
            begin
                if (!hit)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    r.pos = p[POS_W-1:0];
                    if (op == CMD_UPDATE)
                        tab_flags[p] = f;
                    else if (op == CMD_DELETE)
                    begin
                        for (i = p; i + 1 < tab_n; i++)
                        begin
                            tab_keys[i] = tab_keys[i+1];
                            tab_flags[i] = tab_flags[i+1];
                        end
                        tab_n--;
                    end
                    else
                        r.flag = tab_flags[p];
                end
            end
            CMD_SAVE:
            begin
                for (i = 0; i < tab_n; i++)
                begin
                    snap_keys[i] = tab_keys[i];
                    snap_flags[i] = tab_flags[i];
                end
                snap_n = tab_n;
                snap_ok = 1'b1;
            end
            CMD_RESTORE:
            begin
                if (!snap_ok)
                    r.status = ST_NO_SNAPSHOT;
                else
                begin
                    for (i = 0; i < snap_n; i++)
                    begin
                        tab_keys[i] = snap_keys[i];
                        tab_flags[i] = snap_flags[i];
                    end
                    tab_n = snap_n;
                end
            end
            default:
            begin
                // The spare codes change nothing and report plain success.
            end
        endcase
        r.count = tab_n[COUNT_W-1:0];
        expected_results.push_back(r);
    endtask

    task automatic queue_cmd(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] k,
                             input logic f, input int idle_pct, input bit hold_off);
        table_cmd_t c;
        c.op = op;
        c.k = k;
        c.f = f;
        c.idle_pct = idle_pct;
        c.hold_off = hold_off;
        pending_cmds.push_back(c);
    endtask

    // Random commands over a small pool of keys, so that hits, duplicates and
    // deletes are common, with a share of fully random keys that mostly miss.
    task automatic queue_random_phase(input int idle_pct);
        logic [KEY_W-1:0] key_pool[POOL_SIZE];
        logic [CMD_W-1:0] op;
        logic [KEY_W-1:0] k;
        int               pick;
        int               n;
        for (n = 0; n < POOL_SIZE; n++)
            key_pool[n] = KEY_W'($urandom_range(0, (1 << KEY_W) - 1));
        key_pool[0] = '0;
        key_pool[1] = KEY_MAX;
        for (n = 0; n < RANDOM_PHASE_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 34)
                op = CMD_INSERT;
            else if (pick < 46)
                op = CMD_UPDATE;
            else if (pick < 60)
                op = CMD_DELETE;
            else if (pick < 84)
                op = CMD_LOOKUP;
            else if (pick < 90)
                op = CMD_SAVE;
            else if (pick < 96)
                op = CMD_RESTORE;
            else if (pick < 98)
                op = CMD_SPARE_A;
            else
                op = CMD_SPARE_B;
            if ($urandom_range(0, 99) < 85)
                k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                k = KEY_W'($urandom_range(0, (1 << KEY_W) - 1));
            // Now and then the sender waits for the block to drain completely.
            queue_cmd(op, k, 1'($urandom_range(0, 1)), idle_pct,
                      (n == 0) || ($urandom_range(0, 99) < 3));
        end
    endtask

    // Driver. An item is accepted at an edge where start is high and busy is
    // low; at that edge the next item, if any, may be put on the ports. Start
    // gets at most one assignment per edge.
    always @(posedge clk or negedge rst_n)
    begin : driver
        table_cmd_t nxt;
        bit         slot_free;
        bit         accepted;
        bit         take_next;
        if (!rst_n)
        begin
            start <= 1'b0;
            command <= '0;
            key <= '0;
            flag_in <= 1'b0;
            issued_n <= 0;
        end
        else
        begin
            accepted = start && !busy;
            slot_free = !start || !busy;
            take_next = 1'b0;
            if (accepted)
            begin
                predict_table_result(command, key, flag_in);
                issued_n <= issued_n + 1;
            end
            if (slot_free && pending_cmds.size() > 0)
            begin
                nxt = pending_cmds[0];
                if (nxt.hold_off)
                    take_next = !accepted && (issued_n == received_n);
                else
                    take_next = ($urandom_range(0, 99) >= nxt.idle_pct);
            end
            if (take_next)
            begin
                void'(pending_cmds.pop_front());
                start <= 1'b1;
                command <= nxt.op;
                key <= nxt.k;
                flag_in <= nxt.f;
            end
            else if (slot_free)
                start <= 1'b0;
        end
    end

    // Monitor. A result is valid only in its done cycle, so it is taken at
    // the edge that ends that cycle and checked against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        table_result_t exp_r;
        if (!rst_n)
            received_n <= 0;
        else if (done)
        begin
            received_n <= received_n + 1;
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result with nothing expected (status %0d)", status));
            else
            begin
                exp_r = expected_results.pop_front();
                if (status !== exp_r.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              status, exp_r.status));
                if (position !== exp_r.pos)
                    report_mismatch($sformatf("position %0d, expected %0d",
                                              position, exp_r.pos));
                if (flag_out !== exp_r.flag)
                    report_mismatch($sformatf("flag_out %0d, expected %0d",
                                              flag_out, exp_r.flag));
                if (count !== exp_r.count)
                    report_mismatch($sformatf("count %0d, expected %0d",
                                              count, exp_r.count));
            end
        end
    end

    // Watchdog: ends the run when neither an item nor a result moves for
    // far longer than the slowest command can take.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_n <= 0;
        else if (stall_n >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, stall_n);
            $display("CHECK FAILED");
            $finish;
        end
        else
            stall_n <= stall_n + 1;
    end

    initial
    begin : stimulus
        clk = 1'b0;
        rst_n = 1'b0;
        error_n = 0;
        stall_n = 0;
        tab_n = 0;
        snap_n = 0;
        snap_ok = 1'b0;

        // Directed part. A restore before any save has no snapshot to use,
        // and every keyed command on an empty table misses.
        queue_cmd(CMD_RESTORE, '0, 1'b0, 0, 1'b0);
        queue_cmd(CMD_LOOKUP, 14'd5, 1'b0, 0, 1'b0);
        queue_cmd(CMD_UPDATE, 14'd5, 1'b1, 0, 1'b0);
        queue_cmd(CMD_DELETE, 14'd5, 1'b0, 0, 1'b0);
        // Inserts at the end, the front and the middle, then a duplicate.
        queue_cmd(CMD_INSERT, KEY_MAX, 1'b1, 0, 1'b0);
        queue_cmd(CMD_INSERT, '0, 1'b0, 0, 1'b0);
        queue_cmd(CMD_INSERT, 14'h2AAA, 1'b1, 0, 1'b0);
        queue_cmd(CMD_INSERT, 14'h1555, 1'b0, 0, 1'b0);
        queue_cmd(CMD_INSERT, 14'h2AAA, 1'b0, 0, 1'b0);
        queue_cmd(CMD_LOOKUP, '0, 1'b1, 0, 1'b0);
        queue_cmd(CMD_LOOKUP, KEY_MAX, 1'b0, 0, 1'b0);
        queue_cmd(CMD_UPDATE, '0, 1'b1, 0, 1'b0);
        queue_cmd(CMD_LOOKUP, '0, 1'b0, 0, 1'b0);
        queue_cmd(CMD_SPARE_A, 14'h1555, 1'b1, 0, 1'b0);
        queue_cmd(CMD_SPARE_B, KEY_MAX, 1'b1, 0, 1'b0);
        // A snapshot survives the deletes and can be restored twice.
        queue_cmd(CMD_SAVE, '0, 1'b0, 30, 1'b0);
        queue_cmd(CMD_DELETE, 14'h1555, 1'b0, 30, 1'b0);
        queue_cmd(CMD_DELETE, KEY_MAX, 1'b0, 30, 1'b0);
        queue_cmd(CMD_LOOKUP, 14'h1555, 1'b0, 30, 1'b0);
        queue_cmd(CMD_RESTORE, '0, 1'b0, 30, 1'b0);
        queue_cmd(CMD_LOOKUP, 14'h1555, 1'b0, 30, 1'b0);
        queue_cmd(CMD_RESTORE, '0, 1'b0, 30, 1'b0);
        queue_cmd(CMD_DELETE, '0, 1'b0, 30, 1'b1);
        queue_cmd(CMD_LOOKUP, KEY_MAX, 1'b0, 30, 1'b0);
        queue_cmd(CMD_SAVE, '0, 1'b0, 0, 1'b0);

        queue_random_phase(0);
        queue_random_phase(53);
        queue_random_phase(16);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_cmds.size() != 0 || start || issued_n != received_n)
            @(posedge clk);
        // Let any stray result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        if (error_n == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
